// File: rtl/mcv_pkg.sv
`timescale 1ns / 1ps

package mcv_pkg;

	// cost encoding
	localparam logic signed [31:0] COST_INF        = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] COST_MAX_FINITE = 32'sh7FFF_FFFE;
	localparam logic signed [31:0] COST_MIN        = 32'sh8000_0000;

	// field widths
	localparam int COST_W = 32;
	localparam int POS_W  = 6;
	localparam int LEN_W  = 7;

	// reset value of the length register
	localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

	// command codes
	typedef enum logic [1:0] {
		FUNC_SET     = 2'd0,
		FUNC_ADD_ONE = 2'd1,
		FUNC_ADD_ALL = 2'd2,
		FUNC_QUERY   = 2'd3
	} func_t;

	// controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic item_load;
		logic idx_clr;
		logic idx_inc;
		logic clr_en;
		logic set_en;
		logic rd_en;
		logic rd_sel_pos;
		logic res_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t func;
		logic  pos_ok;
		logic  clr_last;
		logic  scan_last;
		logic  out_free;
	} status_t;

endpackage

// File: rtl/mcv_ctrl.sv
`timescale 1ns / 1ps

module mcv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  mcv_pkg::status_t st,
	output mcv_pkg::cmd_t    cmd
);

	mcv_pkg::state_t state_q;
	mcv_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcv_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mcv_pkg::ST_CLEAR: begin
				if (st.clr_last) begin
					state_d = mcv_pkg::ST_IDLE;
				end
			end
			mcv_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = mcv_pkg::ST_DISPATCH;
				end
			end
			mcv_pkg::ST_DISPATCH: begin
				case (st.func)
					mcv_pkg::FUNC_SET: state_d = mcv_pkg::ST_IDLE;
					mcv_pkg::FUNC_ADD_ONE: begin
						state_d = st.pos_ok ? mcv_pkg::ST_DRAIN : mcv_pkg::ST_IDLE;
					end
					default: state_d = mcv_pkg::ST_SCAN;
				endcase
			end
			mcv_pkg::ST_SCAN: begin
				if (st.scan_last) begin
					state_d = mcv_pkg::ST_DRAIN;
				end
			end
			mcv_pkg::ST_DRAIN: begin
				state_d = (st.func == mcv_pkg::FUNC_QUERY) ? mcv_pkg::ST_RESULT
				                                           : mcv_pkg::ST_IDLE;
			end
			mcv_pkg::ST_RESULT: begin
				if (st.out_free) begin
					state_d = mcv_pkg::ST_IDLE;
				end
			end
			default: state_d = mcv_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			mcv_pkg::ST_CLEAR: begin
				cmd.clr_en  = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			mcv_pkg::ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.item_load = s_tvalid;
				cmd.idx_clr   = 1'b1;
			end
			mcv_pkg::ST_DISPATCH: begin
				case (st.func)
					mcv_pkg::FUNC_SET: cmd.set_en = st.pos_ok;
					mcv_pkg::FUNC_ADD_ONE: begin
						cmd.rd_en      = st.pos_ok;
						cmd.rd_sel_pos = 1'b1;
					end
					default: cmd.rd_en = 1'b0;
				endcase
			end
			mcv_pkg::ST_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			mcv_pkg::ST_RESULT: begin
				cmd.res_load = st.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/mcv_datapath.sv
`timescale 1ns / 1ps

module mcv_datapath #(
	parameter int MAX_LENGTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mcv_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic [1:0]                   s_tuser,
	input  logic [39:0]                  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [39:0]                  m_tdata,
	input  mcv_pkg::cmd_t                cmd,
	output mcv_pkg::status_t             st
);

	localparam int AW      = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int IW      = (AW > mcv_pkg::LEN_W) ? AW : mcv_pkg::LEN_W;
	localparam int LEN_CAP = (MAX_LENGTH < 127) ? MAX_LENGTH : 127;

	// cost memory
	logic [mcv_pkg::COST_W-1:0] cost_mem_q [MAX_LENGTH];

	// item registers
	mcv_pkg::func_t                    func_q;
	logic [mcv_pkg::POS_W-1:0]         pos_q;
	logic signed [mcv_pkg::COST_W-1:0] cost_q;

	logic [mcv_pkg::LEN_W-1:0] vl_q;
	logic [mcv_pkg::LEN_W-1:0] len;
	logic [mcv_pkg::LEN_W-1:0] len_m1;
	logic [IW-1:0]             idx_q;
	logic [AW-1:0]             rd_addr;

	logic                              rd_s1;
	logic [AW-1:0]                     addr_s1;
	logic signed [mcv_pkg::COST_W-1:0] rd_data_s1;

	logic signed [mcv_pkg::COST_W:0]   sum;
	logic signed [mcv_pkg::COST_W-1:0] add_res;
	logic                              add_clamp;
	logic                              wb_en;
	logic                              fold_en;

	logic                              we;
	logic [AW-1:0]                     wr_addr;
	logic [mcv_pkg::COST_W-1:0]        wr_data;

	logic signed [mcv_pkg::COST_W-1:0] best_q;
	logic [mcv_pkg::POS_W-1:0]         best_pos_q;
	logic                              flag_q;
	logic                              out_valid_q;
	logic [39:0]                       out_data_q;

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vl_q <= mcv_pkg::LEN_RESET;
		end else if (cfg_we) begin
			vl_q <= cfg_wdata;
		end
	end

	// effective length, zero acts as one, capped at MAX_LENGTH and at 127
	always_comb begin
		if (vl_q == '0) begin
			len = 7'd1;
		end else if (vl_q > 7'(LEN_CAP)) begin
			len = 7'(LEN_CAP);
		end else begin
			len = vl_q;
		end
		len_m1 = len - 7'd1;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			func_q <= mcv_pkg::func_t'(s_tuser);
			pos_q  <= s_tdata[5:0];
			cost_q <= s_tdata[37:6];
		end
	end

	// entry index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	assign rd_addr = cmd.rd_sel_pos ? AW'(pos_q) : idx_q[AW-1:0];

	// registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= rd_addr;
		rd_data_s1 <= cost_mem_q[rd_addr];
	end

	// min-plus add with clamp, infinity absorbs
	always_comb begin
		sum       = {rd_data_s1[31], rd_data_s1} + {cost_q[31], cost_q};
		add_clamp = 1'b0;
		if (rd_data_s1 == mcv_pkg::COST_INF || cost_q == mcv_pkg::COST_INF) begin
			add_res = mcv_pkg::COST_INF;
		end else if (sum > 33'(mcv_pkg::COST_MAX_FINITE)) begin
			add_res   = mcv_pkg::COST_MAX_FINITE;
			add_clamp = 1'b1;
		end else if (sum < 33'(mcv_pkg::COST_MIN)) begin
			add_res   = mcv_pkg::COST_MIN;
			add_clamp = 1'b1;
		end else begin
			add_res = sum[31:0];
		end
	end

	assign wb_en   = rd_s1 && (func_q != mcv_pkg::FUNC_QUERY);
	assign fold_en = rd_s1 && (func_q == mcv_pkg::FUNC_QUERY);

	// write port select
	always_comb begin
		we      = 1'b1;
		wr_addr = addr_s1;
		wr_data = add_res;
		if (cmd.clr_en) begin
			wr_addr = idx_q[AW-1:0];
			wr_data = '0;
		end else if (cmd.set_en) begin
			wr_addr = AW'(pos_q);
			wr_data = cost_q;
		end else if (!wb_en) begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			cost_mem_q[wr_addr] <= wr_data;
		end
	end

	// running minimum, strict compare keeps the first index
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			best_q     <= mcv_pkg::COST_INF;
			best_pos_q <= '0;
		end else if (fold_en && rd_data_s1 < best_q) begin
			best_q     <= rd_data_s1;
			best_pos_q <= mcv_pkg::POS_W'(addr_s1);
		end
	end

	// sticky clamp flag, cleared by a query result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (cmd.res_load) begin
			flag_q <= 1'b0;
		end else if (wb_en && add_clamp) begin
			flag_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_data_q <= {1'b0, flag_q, best_pos_q, best_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// status
	assign st.func      = func_q;
	assign st.pos_ok    = {1'b0, pos_q} < len;
	assign st.clr_last  = idx_q == IW'(MAX_LENGTH - 1);
	assign st.scan_last = idx_q == IW'(len_m1);
	assign st.out_free  = !out_valid_q || m_tready;

	// at most one source on the write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_en, cmd.set_en, wb_en}))
		else $error("write port conflict");

	// a result is never loaded over one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || m_tready))
		else $error("result overwritten");

	// indexed reads stay inside the memory
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && !cmd.rd_sel_pos) |-> (idx_q <= IW'(MAX_LENGTH - 1)))
		else $error("scan index out of range");

	// a scan read lands on an entry below the length
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && !cmd.rd_sel_pos) |-> (idx_q <= IW'(len_m1)))
		else $error("scan past the used length");

endmodule

// File: rtl/min_plus_cost_vector.sv
`timescale 1ns / 1ps
// channel   | dir | handshake         | payload
// ----------+-----+-------------------+------------------------------------------
// s_*       | in  | s_tvalid/s_tready | tuser: func; tdata: position, cost
// m_*       | out | m_tvalid/m_tready | tdata: min_cost, min_position, overflow_seen
// cfg_*     | in  | cfg_we            | cfg_wdata: vector_length
//
// set writes its entry in dispatch; add to one entry reads it in dispatch and
// writes it back in drain, skipping drain when the position is unused; add to
// all and query scan the used length, one memory entry per cycle, then drain.
// after reset a clearing pass writes zero to all MAX_LENGTH entries, one per
// cycle, before the first item is taken; config writes are taken meanwhile.
// a query result waits in an output register, so the next item is taken
// while it is stalled; a second query holds at its end until the first goes.

module min_plus_cost_vector #(
	parameter int MAX_LENGTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,  // vector_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,    // func
	input  logic [39:0] s_tdata,    // position[5:0], cost[37:6], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata     // min_cost[31:0], min_position[37:32],
	                                // overflow_seen[38], zero fill
);

	mcv_pkg::cmd_t    cmd;
	mcv_pkg::status_t st;

	// sequencer
	mcv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// memory, adder and minimum tracking
	mcv_datapath #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
